[rtl/mhpq_pkg.sv]
// Shared types, codes and defaults of the min-heap priority queue.
package mhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_UP,
    CMD_UP_CMP,
    CMD_LAST,
    CMD_DN_L,
    CMD_DN_R,
    CMD_DN_CMP
  } cmd_e;

  typedef struct packed {
    logic full;
    logic empty;
    logic one;
    logic pos_zero;
    logic parent_gt;
    logic lc_out;
    logic stay;
  } dp_status_t;

endpackage

[rtl/min_heap_priority_queue.sv]
// Top level of the binary min-heap priority queue.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  request  | start / busy            | kind_i, key_i
//  result   | done_o (1-cycle strobe) | value_o, status_o, count_o, min_value_o,
//           |                         | min_valid_o
//
// One item at a time; the steps from the accepting edge to the result strobe are:
// Insert: straight to the result when full; else per level the key climbs a parent
// read, then a compare and write-back; at the root the key is written in place.
// Extract: straight to the result when empty or when it takes the last key; else the
// last entry is read and moved to the root, then per level it sinks a left read, a
// right read and a compare and write-back, until it has no children or stops above them.
// Reset clears only the sequencer state and the entry count; the key store needs no clearing pass.
// The result strobe cannot be held off; busy drops in the cycle after it.
module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  output logic                       done_o,
  output logic signed [KEY_BITS-1:0] value_o,
  output logic [1:0]                 status_o,
  output logic [CNT_W-1:0]           count_o,
  output logic signed [KEY_BITS-1:0] min_value_o,
  output logic                       min_valid_o
);

  mhpq_pkg::cmd_e       cmd;
  mhpq_pkg::dp_status_t stat;

  // sequencer: decides each step from datapath flags
  mhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // datapath: key store, hole-based sift up / sift down, result registers
  mhpq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .stat_o      (stat),
    .value_o     (value_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .min_value_o (min_value_o),
    .min_valid_o (min_valid_o)
  );

endmodule

[rtl/mhpq_ram.sv]
// Generic single-port-write, registered-read RAM.
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mhpq_ctrl.sv]
// Sequencer for insert / extract requests of the min-heap.
module mhpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                kind_i,
  input  mhpq_pkg::dp_status_t stat_i,
  output mhpq_pkg::cmd_e      cmd_o,
  output logic                busy,
  output logic                done_o
);

  mhpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = mhpq_pkg::CMD_NONE;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o = mhpq_pkg::CMD_ACCEPT;
          if (kind_i == mhpq_pkg::KIND_INSERT) begin
            state_d = stat_i.full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP;
          end else begin
            state_d = (stat_i.empty || stat_i.one) ? mhpq_pkg::S_DONE : mhpq_pkg::S_LAST;
          end
        end
      end
      mhpq_pkg::S_UP: begin
        cmd_o   = mhpq_pkg::CMD_UP;
        state_d = stat_i.pos_zero ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        cmd_o   = mhpq_pkg::CMD_UP_CMP;
        state_d = stat_i.parent_gt ? mhpq_pkg::S_UP : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_LAST: begin
        cmd_o   = mhpq_pkg::CMD_LAST;
        state_d = mhpq_pkg::S_DN_L;
      end
      mhpq_pkg::S_DN_L: begin
        cmd_o   = mhpq_pkg::CMD_DN_L;
        state_d = stat_i.lc_out ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_R;
      end
      mhpq_pkg::S_DN_R: begin
        cmd_o   = mhpq_pkg::CMD_DN_R;
        state_d = mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        cmd_o   = mhpq_pkg::CMD_DN_CMP;
        state_d = stat_i.stay ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_L;
      end
      mhpq_pkg::S_DONE: begin
        done_o  = 1'b1;
        state_d = mhpq_pkg::S_IDLE;
      end
      default: begin
        state_d = mhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/mhpq_dp.sv]
// Heap datapath: key store, count, sift position and result registers.
module mhpq_dp #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  localparam int unsigned ADDR_W  = $clog2(CAPACITY),
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mhpq_pkg::cmd_e             cmd_i,
  input  logic                       kind_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  output mhpq_pkg::dp_status_t       stat_o,
  output logic signed [KEY_BITS-1:0] value_o,
  output logic [1:0]                 status_o,
  output logic [CNT_W-1:0]           count_o,
  output logic signed [KEY_BITS-1:0] min_value_o,
  output logic                       min_valid_o
);

  localparam int unsigned IDX_W = ADDR_W + 2;

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [ADDR_W-1:0]          pos_q, pos_d;
  logic signed [KEY_BITS-1:0] cur_q, cur_d;
  logic signed [KEY_BITS-1:0] lk_q, lk_d;
  logic                       rc_ok_q, rc_ok_d;
  logic signed [KEY_BITS-1:0] root_q, root_d;
  logic signed [KEY_BITS-1:0] value_q, value_d;
  logic [1:0]                 status_q, status_d;

  logic                       we;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic [KEY_BITS-1:0]        wdata, rdata;
  logic signed [KEY_BITS-1:0] rkey;

  logic [ADDR_W-1:0]          parent;
  logic [IDX_W-1:0]           lc, rc;
  logic                       lbetter, take_r;
  logic signed [KEY_BITS-1:0] bkey;

  mhpq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rkey    = $signed(rdata);
  assign parent  = ADDR_W'((pos_q - 1'b1) >> 1);
  assign lc      = IDX_W'({pos_q, 1'b1});
  assign rc      = lc + 1'b1;
  // down step: strict compares, left child wins ties
  assign lbetter = lk_q < cur_q;
  assign bkey    = lbetter ? lk_q : cur_q;
  assign take_r  = rc_ok_q && (rkey < bkey);

  assign stat_o.full      = cnt_q == CNT_W'(CAPACITY);
  assign stat_o.empty     = cnt_q == '0;
  assign stat_o.one       = cnt_q == CNT_W'(1);
  assign stat_o.pos_zero  = pos_q == '0;
  assign stat_o.parent_gt = rkey > cur_q;
  assign stat_o.lc_out    = lc >= IDX_W'(cnt_q);
  assign stat_o.stay      = !lbetter && !take_r;

  always_comb begin
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    cur_d    = cur_q;
    lk_d     = lk_q;
    rc_ok_d  = rc_ok_q;
    value_d  = value_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = cur_q;
    raddr    = parent;
    case (cmd_i)
      mhpq_pkg::CMD_ACCEPT: begin
        value_d  = '0;
        status_d = mhpq_pkg::ST_OK;
        if (kind_i == mhpq_pkg::KIND_INSERT) begin
          if (stat_o.full) begin
            status_d = mhpq_pkg::ST_FULL;
          end else begin
            cur_d = key_i;
            pos_d = cnt_q[ADDR_W-1:0];
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          if (stat_o.empty) begin
            status_d = mhpq_pkg::ST_EMPTY;
          end else begin
            value_d = root_q;
            cnt_d   = cnt_q - 1'b1;
            raddr   = ADDR_W'(cnt_q - 1'b1);
          end
        end
      end
      mhpq_pkg::CMD_UP: begin
        // at the root: drop the key in place; else fetch the parent
        we = stat_o.pos_zero;
      end
      mhpq_pkg::CMD_UP_CMP: begin
        we = 1'b1;
        if (stat_o.parent_gt) begin
          wdata = rdata;
          pos_d = parent;
        end
      end
      mhpq_pkg::CMD_LAST: begin
        cur_d = rkey;
        pos_d = '0;
      end
      mhpq_pkg::CMD_DN_L: begin
        we    = stat_o.lc_out;
        raddr = lc[ADDR_W-1:0];
      end
      mhpq_pkg::CMD_DN_R: begin
        lk_d    = rkey;
        rc_ok_d = rc < IDX_W'(cnt_q);
        raddr   = rc[ADDR_W-1:0];
      end
      mhpq_pkg::CMD_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata = rdata;
          pos_d = rc[ADDR_W-1:0];
        end else if (lbetter) begin
          wdata = lk_q;
          pos_d = lc[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // shadow of entry 0 for the minimum report
  assign root_d = (we && waddr == '0) ? $signed(wdata) : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    lk_q     <= lk_d;
    rc_ok_q  <= rc_ok_d;
    root_q   <= root_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign value_o     = value_q;
  assign status_o    = status_q;
  assign count_o     = cnt_q;
  assign min_valid_o = cnt_q != '0;
  assign min_value_o = (cnt_q != '0) ? root_q : '0;

endmodule
